>>> rtl/cwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_pkg
// shared types and constants of the windowed 2d convolution with clamp
// ----------------------------------------------------------------------------
package cwc_pkg;

    localparam int PIXEL_FRAC = 15;
    localparam int COEF_FRAC  = 16;

    localparam int PIXW   = 16;
    localparam int COEFW  = 24;
    localparam int CIDXW  = 7;
    localparam int CXW    = 11;
    localparam int CYW    = 12;
    localparam int WREGW  = 11;
    localparam int HREGW  = 13;
    localparam int BREGW  = 4;
    localparam int KREGW  = 4;
    localparam int COLW   = 12;
    localparam int ROWW   = 14;

    localparam int CFG_IDXW  = 8;
    localparam int CFG_DATAW = 16;

    localparam logic [CFG_IDXW-1:0] CFG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDXW-1:0] CFG_IMAGE_HEIGHT = 8'd1;
    localparam logic [CFG_IDXW-1:0] CFG_BORDER       = 8'd2;
    localparam logic [CFG_IDXW-1:0] CFG_KERNEL_SIZE  = 8'd3;

    localparam logic ACT_COEF  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [CIDXW-1:0]         coef_index;
        logic signed [COEFW-1:0]  coef_value;
        logic [PIXW-1:0]          pixel_value;
    } t_in;

    typedef struct packed {
        logic [CXW-1:0]  center_x;
        logic [CYW-1:0]  center_y;
        logic [PIXW-1:0] value;
        logic            last_of_frame;
    } t_out;

    typedef struct packed {
        logic [WREGW-1:0] image_width;
        logic [HREGW-1:0] image_height;
        logic [BREGW-1:0] border;
        logic [KREGW-1:0] ksize;
    } t_cfg;

    typedef struct packed {
        logic [CXW-1:0] center_x;
        logic [CYW-1:0] center_y;
        logic           last_of_frame;
    } t_meta;

    typedef struct packed {
        logic                     is_pix;
        logic [CIDXW-1:0]         coef_index;
        logic signed [COEFW-1:0]  coef_value;
        logic [PIXW-1:0]          pixel;
        logic                     emit;
        t_meta                    meta;
    } t_mid;

endpackage

>>> rtl/cwc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_fifo
// small register fifo, one write and one read per cycle; a write while full or a read while empty is ignored
// ----------------------------------------------------------------------------
module cwc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_wr, do_rd;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign do_wr   = i_wr & ~o_full;
    assign do_rd   = i_rd & ~o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(do_wr) - CW'(do_rd);
        end
    end
endmodule

>>> rtl/cwc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_front
// accepts items, keeps raster counters and classifies each pixel
// ----------------------------------------------------------------------------
module cwc_front #(
    parameter int MAX_LINE = 2048,
    parameter int LCW      = 11
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cwc_pkg::t_cfg   i_cfg,
    input  logic            i_push,
    input  cwc_pkg::t_in    i_item,
    input  logic            i_q_full,
    input  logic            i_hold,
    output logic            o_full,
    output logic            o_wr,
    output cwc_pkg::t_mid   o_mid,
    output logic [LCW-1:0]  o_lc
);
    logic [cwc_pkg::COLW-1:0] r_col, n_col;
    logic [cwc_pkg::ROWW-1:0] r_row, n_row;
    logic [LCW-1:0]           r_lc, n_lc;
    logic [11:0]              line_len;
    logic [13:0]              frame_rows;
    logic                     col_wrap, row_wrap, in_x, in_y, accept, is_pix;
    logic [cwc_pkg::KREGW-1:0] lead;
    logic signed [12:0]       pcx;
    logic signed [14:0]       pcy;

    assign o_full = i_q_full | i_hold;
    assign accept = i_push & ~o_full;
    assign o_wr   = accept;
    assign is_pix = (i_item.action == cwc_pkg::ACT_PIXEL);

    assign line_len   = {1'b0, i_cfg.image_width} + {7'b0, i_cfg.border, 1'b0};
    assign frame_rows = {1'b0, i_cfg.image_height} + {9'b0, i_cfg.border, 1'b0};
    assign col_wrap   = (r_col + cwc_pkg::COLW'(1)) >= line_len;
    assign row_wrap   = (r_row + cwc_pkg::ROWW'(1)) >= frame_rows;

    assign lead = i_cfg.ksize - cwc_pkg::KREGW'(1) - (i_cfg.ksize >> 1);
    assign pcx  = 13'(r_col) - 13'(lead) - 13'(i_cfg.border);
    assign pcy  = 15'(r_row) - 15'(lead) - 15'(i_cfg.border);
    assign in_x = ~pcx[12] && (pcx[11:0] < {1'b0, i_cfg.image_width});
    assign in_y = ~pcy[14] && (pcy[13:0] < {1'b0, i_cfg.image_height});

    always_comb begin
        o_mid.is_pix             = is_pix;
        o_mid.coef_index         = i_item.coef_index;
        o_mid.coef_value         = i_item.coef_value;
        o_mid.pixel              = i_item.pixel_value;
        o_mid.emit               = is_pix & in_x & in_y;
        o_mid.meta.center_x      = pcx[cwc_pkg::CXW-1:0];
        o_mid.meta.center_y      = pcy[cwc_pkg::CYW-1:0];
        o_mid.meta.last_of_frame =
            (pcx[11:0] == {1'b0, i_cfg.image_width} - 12'd1) &&
            (pcy[13:0] == {1'b0, i_cfg.image_height} - 14'd1);
        o_lc = r_lc;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_lc  = r_lc;
        if (accept && is_pix) begin
            if (col_wrap) begin
                n_col = '0;
                n_lc  = '0;
                n_row = row_wrap ? '0 : r_row + cwc_pkg::ROWW'(1);
            end else begin
                n_col = r_col + cwc_pkg::COLW'(1);
                n_lc  = (r_lc == LCW'(MAX_LINE - 1)) ? '0 : r_lc + LCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_lc  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_lc  <= n_lc;
        end
    end
endmodule

>>> rtl/cwc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_back
// line stores, window, coefficient table, multiplier lanes, adder tree, clamp
// ----------------------------------------------------------------------------
module cwc_back #(
    parameter int MAX_KSIZE = 9,
    parameter int MAX_LINE  = 2048,
    parameter int LCW       = 11,
    parameter int RDEPTH    = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [cwc_pkg::KREGW-1:0]  i_k,
    input  logic                       i_q_empty,
    input  cwc_pkg::t_mid              i_mid,
    input  logic [LCW-1:0]             i_lc,
    input  logic                       i_res_pop,
    output logic                       o_q_rd,
    output logic                       o_clearing,
    output logic                       o_res_wr,
    output cwc_pkg::t_out              o_res
);
    localparam int NCOEF = MAX_KSIZE * MAX_KSIZE;
    localparam int LROWS = (MAX_KSIZE > 1) ? MAX_KSIZE - 1 : 1;
    localparam int CLG   = $clog2(NCOEF);
    localparam int LV    = (CLG + 1) / 2 > 0 ? (CLG + 1) / 2 : 1;
    localparam int PAD   = 4 ** LV;
    localparam int PRODW = cwc_pkg::COEFW + cwc_pkg::PIXW + 1;
    localparam int SUMW  = PRODW + 2 * LV;
    localparam int CREDW = $clog2(RDEPTH + 1);
    localparam int PIXW  = cwc_pkg::PIXW;
    localparam int KW    = cwc_pkg::KREGW;

    logic take;
    logic [CREDW-1:0] r_cred;

    // clearing pass over the line stores
    logic           r_clr_busy;
    logic [LCW-1:0] r_clr_addr;

    // stage 1
    logic            r_s1_v, r_s1_emit, r_same;
    logic [PIXW-1:0] r_s1_pix;
    logic [LCW-1:0]  r_s1_lc;
    cwc_pkg::t_meta  r_s1_meta;

    // line store ports
    logic [PIXW-1:0] r_q    [LROWS];
    logic [PIXW-1:0] r_wd   [LROWS];
    logic            r_wen  [LROWS];
    logic [PIXW-1:0] ls_rd  [LROWS];
    logic [PIXW-1:0] wd     [LROWS];
    logic            we_pix [LROWS];

    logic [PIXW-1:0] colv   [MAX_KSIZE];
    logic [PIXW-1:0] r_win  [MAX_KSIZE][MAX_KSIZE];

    logic signed [cwc_pkg::COEFW-1:0] r_tab  [NCOEF];
    logic signed [cwc_pkg::COEFW-1:0] r_ceff [NCOEF];

    logic           r_s2_v;
    cwc_pkg::t_meta r_s2_meta;

    logic signed [SUMW-1:0] r_tr [LV+1][PAD];
    logic                   r_vp [LV+1];
    cwc_pkg::t_meta         r_mp [LV+1];

    logic            r_out_v;
    cwc_pkg::t_out   r_out;
    logic signed [SUMW-1:0] sum, rnd, shv;
    logic [PIXW-1:0] n_value;

    assign take       = ~i_q_empty & ~r_clr_busy & (r_cred < CREDW'(RDEPTH));
    assign o_q_rd     = take;
    assign o_clearing = r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred     <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_cred <= r_cred + CREDW'(take & i_mid.is_pix & i_mid.emit) - CREDW'(i_res_pop);
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + LCW'(1);
                if (r_clr_addr == LCW'(MAX_LINE - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s1_emit <= 1'b0;
            r_same    <= 1'b0;
        end else begin
            r_s1_v    <= take & i_mid.is_pix;
            r_s1_emit <= take & i_mid.is_pix & i_mid.emit;
            r_same    <= take & i_mid.is_pix & r_s1_v & (i_lc == r_s1_lc);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix  <= i_mid.pixel;
        r_s1_lc   <= i_lc;
        r_s1_meta <= i_mid.meta;
    end

    // coefficient table
    for (genvar i = 0; i < NCOEF; i++) begin : g_tab
        always_ff @(posedge i_clk) begin
            if (take && !i_mid.is_pix && int'(i_mid.coef_index) == i) begin
                r_tab[i] <= i_mid.coef_value;
            end
        end
    end

    // line store rows
    for (genvar j = 0; j < LROWS; j++) begin : g_line
        logic [PIXW-1:0] r_mem [MAX_LINE];
        logic [LCW-1:0]  wa;

        assign ls_rd[j]  = (r_same && r_wen[j]) ? r_wd[j] : r_q[j];
        assign we_pix[j] = r_s1_v && (KW'(j + 1) < i_k);
        if (j == 0) begin : g_first
            assign wd[j] = r_s1_pix;
        end else begin : g_next
            assign wd[j] = ls_rd[j-1];
        end
        assign wa = r_clr_busy ? r_clr_addr : r_s1_lc;

        always_ff @(posedge i_clk) begin
            if (r_clr_busy || we_pix[j]) begin
                r_mem[wa] <= r_clr_busy ? '0 : wd[j];
            end
            r_q[j] <= r_mem[i_lc];
        end

        always_ff @(posedge i_clk) begin
            r_wen[j] <= we_pix[j];
            r_wd[j]  <= wd[j];
        end
    end

    // new window column
    for (genvar r = 0; r < MAX_KSIZE; r++) begin : g_colv
        always_comb begin
            colv[r] = '0;
            if (KW'(r + 1) == i_k) begin
                colv[r] = r_s1_pix;
            end else begin
                for (int j = 0; j < LROWS; j++) begin
                    if ({1'b0, i_k} == 5'(r + j + 2)) begin
                        colv[r] = ls_rd[j];
                    end
                end
            end
        end
    end

    // window registers
    for (genvar r = 0; r < MAX_KSIZE; r++) begin : g_wr
        for (genvar c = 0; c < MAX_KSIZE; c++) begin : g_wc
            localparam int CN = (c + 1 < MAX_KSIZE) ? c + 1 : 0;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_win[r][c] <= '0;
                end else if (r_s1_v && KW'(r) < i_k) begin
                    if (KW'(c + 1) == i_k) begin
                        r_win[r][c] <= colv[r];
                    end else if (KW'(c + 1) < i_k) begin
                        r_win[r][c] <= r_win[r][CN];
                    end
                end
            end
        end
    end

    // coefficient remap by kernel size
    for (genvar r = 0; r < MAX_KSIZE; r++) begin : g_cr
        for (genvar c = 0; c < MAX_KSIZE; c++) begin : g_cc
            logic signed [cwc_pkg::COEFW-1:0] sel;
            always_comb begin
                sel = '0;
                for (int kk = 1; kk <= MAX_KSIZE; kk++) begin
                    if (i_k == KW'(kk) && r < kk && c < kk) begin
                        sel = r_tab[r * kk + c];
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                r_ceff[r * MAX_KSIZE + c] <= sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_meta <= r_s1_meta;
    end

    // multiplier lanes
    for (genvar n = 0; n < PAD; n++) begin : g_mul
        if (n < NCOEF) begin : g_lane
            localparam int WR = n / MAX_KSIZE;
            localparam int WC = n % MAX_KSIZE;
            logic signed [PRODW-1:0] prod;
            assign prod = r_ceff[n] * $signed({1'b0, r_win[WR][WC]});
            always_ff @(posedge i_clk) begin
                r_tr[0][n] <= SUMW'(prod);
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_tr[0][n] <= '0;
            end
        end
    end

    // registered adder tree, four inputs per node
    for (genvar l = 0; l < LV; l++) begin : g_lvl
        for (genvar n = 0; n < (PAD >> (2 * (l + 1))); n++) begin : g_node
            always_ff @(posedge i_clk) begin
                r_tr[l+1][n] <= r_tr[l][4*n] + r_tr[l][4*n+1] +
                                r_tr[l][4*n+2] + r_tr[l][4*n+3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l <= LV; l++) begin
                r_vp[l] <= 1'b0;
            end
        end else begin
            r_vp[0] <= r_s2_v;
            for (int l = 0; l < LV; l++) begin
                r_vp[l+1] <= r_vp[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mp[0] <= r_s2_meta;
        for (int l = 0; l < LV; l++) begin
            r_mp[l+1] <= r_mp[l];
        end
    end

    // round, shift and clamp to 0..1
    always_comb begin
        sum = r_tr[LV][0];
        rnd = sum + (SUMW'(1) <<< (cwc_pkg::COEF_FRAC - 1));
        shv = rnd >>> cwc_pkg::COEF_FRAC;
        if (sum[SUMW-1] || sum == '0) begin
            n_value = '0;
        end else if (shv > (SUMW'(1) <<< cwc_pkg::PIXEL_FRAC)) begin
            n_value = PIXW'(1) << cwc_pkg::PIXEL_FRAC;
        end else begin
            n_value = shv[PIXW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_vp[LV];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.center_x      <= r_mp[LV].center_x;
        r_out.center_y      <= r_mp[LV].center_y;
        r_out.last_of_frame <= r_mp[LV].last_of_frame;
        r_out.value         <= n_value;
    end

    assign o_res_wr = r_out_v;
    assign o_res    = r_out;
endmodule

>>> rtl/conv2d_window_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_window_clamp
// streaming square 2d convolution over a padded frame, result clamped to 0..1
// ----------------------------------------------------------------------------
// throughput: one item per clock, in and out, unless full is held high by the clearing pass or by unpopped results
// path: a pixel transfer passes the item queue, stage 1, the window registers, the product registers, the adder
//   tree (four levels at MAX_KSIZE 9) and the output register into the result queue
// reset: counters, window and queues clear at once; the line stores are then
//   zeroed one column a cycle over all MAX_LINE columns, with full held high
module conv2d_window_clamp #(
    parameter int MAX_KSIZE = 9,
    parameter int MAX_LINE  = 2048
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  cwc_pkg::t_in                     i_in,
    output logic                             empty,
    input  logic                             pop,
    output cwc_pkg::t_out                    o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cwc_pkg::CFG_IDXW-1:0]     i_cfg_index,
    input  logic [cwc_pkg::CFG_DATAW-1:0]    i_cfg_data
);
    localparam int LCW       = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int MID_DEPTH = 4;
    localparam int RES_DEPTH = 16;
    localparam int MIDW      = LCW + $bits(cwc_pkg::t_mid);

    logic [cwc_pkg::WREGW-1:0] r_image_width;
    logic [cwc_pkg::HREGW-1:0] r_image_height;
    logic [cwc_pkg::BREGW-1:0] r_border;
    logic [cwc_pkg::KREGW-1:0] r_kernel_size;
    logic [cwc_pkg::KREGW-1:0] keff;
    cwc_pkg::t_cfg             cfg;

    logic            q_wr, q_full, q_empty, q_rd, clearing;
    cwc_pkg::t_mid   f_mid, b_mid;
    logic [LCW-1:0]  f_lc, b_lc;
    logic [MIDW-1:0] q_out;
    logic            res_wr, res_full, res_rd;
    cwc_pkg::t_out   res_in, res_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 11'd1024;
            r_image_height <= 13'd1024;
            r_border       <= 4'd4;
            r_kernel_size  <= 4'd5;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cwc_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[cwc_pkg::WREGW-1:0];
                cwc_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[cwc_pkg::HREGW-1:0];
                cwc_pkg::CFG_BORDER:       r_border       <= i_cfg_data[cwc_pkg::BREGW-1:0];
                cwc_pkg::CFG_KERNEL_SIZE:  r_kernel_size  <= i_cfg_data[cwc_pkg::KREGW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_kernel_size == '0) begin
            keff = cwc_pkg::KREGW'(1);
        end else if (r_kernel_size > cwc_pkg::KREGW'(MAX_KSIZE)) begin
            keff = cwc_pkg::KREGW'(MAX_KSIZE);
        end else begin
            keff = r_kernel_size;
        end
        cfg.image_width  = r_image_width;
        cfg.image_height = r_image_height;
        cfg.border       = r_border;
        cfg.ksize        = keff;
    end

    cwc_front #(
        .MAX_LINE (MAX_LINE),
        .LCW      (LCW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_push   (push),
        .i_item   (i_in),
        .i_q_full (q_full),
        .i_hold   (clearing),
        .o_full   (full),
        .o_wr     (q_wr),
        .o_mid    (f_mid),
        .o_lc     (f_lc)
    );

    cwc_fifo #(
        .WIDTH (MIDW),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  ({f_lc, f_mid}),
        .i_rd    (q_rd),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign b_lc  = q_out[MIDW-1 -: LCW];
    assign b_mid = cwc_pkg::t_mid'(q_out[$bits(cwc_pkg::t_mid)-1:0]);

    cwc_back #(
        .MAX_KSIZE (MAX_KSIZE),
        .MAX_LINE  (MAX_LINE),
        .LCW       (LCW),
        .RDEPTH    (RES_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_k        (keff),
        .i_q_empty  (q_empty),
        .i_mid      (b_mid),
        .i_lc       (b_lc),
        .i_res_pop  (res_rd),
        .o_q_rd     (q_rd),
        .o_clearing (clearing),
        .o_res_wr   (res_wr),
        .o_res      (res_in)
    );

    assign res_rd = pop & ~empty;

    cwc_fifo #(
        .WIDTH ($bits(cwc_pkg::t_out)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_data  (res_in),
        .i_rd    (res_rd),
        .o_data  (res_out),
        .o_empty (empty),
        .o_full  (res_full)
    );

    assign o_out = res_out;

    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_wr |-> !res_full)
        else $error("result queue written while full");

    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr |-> !q_full)
        else $error("item queue written while full");

    a_value_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out.value <= 16'd32768))
        else $error("result above 1.0");
endmodule

>>> dv/tb_conv2d_window_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_window_clamp
// drives coefficient and padded-frame pixel transfers into the convolution
// block under several frame and kernel settings, predicts each centre result
// in a cycle-free model of the line stores and window, and checks every
// result transfer field by field against the oldest predicted one
// ----------------------------------------------------------------------------
module tb_conv2d_window_clamp;

    localparam int KMAX  = 9;
    localparam int LMAX  = 2048;
    localparam int DRAIN = 40;

    logic          i_clk;
    logic          i_rst_n;
    logic          push;
    logic          full;
    cwc_pkg::t_in  i_in;
    logic          empty;
    logic          pop = 1'b0;
    cwc_pkg::t_out o_out;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [cwc_pkg::CFG_IDXW-1:0]  i_cfg_index;
    logic [cwc_pkg::CFG_DATAW-1:0] i_cfg_data;

    conv2d_window_clamp u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // prediction state
    int unsigned width_q, height_q, border_q, ksize_q;
    longint      coef_tbl [KMAX*KMAX];
    logic [15:0] line_mem [KMAX][LMAX];
    logic [15:0] win      [KMAX][KMAX];
    int unsigned col_cnt, row_cnt;
    cwc_pkg::t_out pending_q [$];

    int  err_cnt;
    int  rand_items;
    bit  calm;
    int  pop_hold = 0;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [15:0] conv_value(int unsigned k);
        longint sum;
        longint rnd;
        sum = 0;
        for (int r = 0; r < k; r++)
            for (int c = 0; c < k; c++)
                sum += coef_tbl[r*k + c] * longint'(win[r][c]);
        if (sum <= 0)
            return 16'd0;
        rnd = (sum + (64'sd1 << (cwc_pkg::COEF_FRAC - 1))) >>> cwc_pkg::COEF_FRAC;
        if (rnd > (64'sd1 << cwc_pkg::PIXEL_FRAC))
            rnd = 64'sd1 << cwc_pkg::PIXEL_FRAC;
        return rnd[15:0];
    endfunction

    function automatic void predict_window(cwc_pkg::t_in it);
        int unsigned k, lc, half, lead, line_len, frame_rows;
        logic [15:0] colv [KMAX];
        int pcx, pcy;
        cwc_pkg::t_out res;
        if (it.action == cwc_pkg::ACT_COEF) begin
            if (it.coef_index < KMAX*KMAX)
                coef_tbl[it.coef_index] = longint'(it.coef_value);
            return;
        end
        k = (ksize_q == 0) ? 1 : (ksize_q > KMAX ? KMAX : ksize_q);
        lc = col_cnt % LMAX;
        line_len = width_q + 2*border_q;
        frame_rows = height_q + 2*border_q;
        colv[k-1] = it.pixel_value;
        for (int r = 0; r + 1 < k; r++)
            colv[k-2-r] = line_mem[r][lc];
        for (int r = k - 1; r >= 2; r--)
            line_mem[r-1][lc] = line_mem[r-2][lc];
        if (k >= 2)
            line_mem[0][lc] = it.pixel_value;
        for (int r = 0; r < k; r++) begin
            for (int c = 0; c + 1 < k; c++)
                win[r][c] = win[r][c+1];
            win[r][k-1] = colv[r];
        end
        half = k / 2;
        lead = k - 1 - half;
        pcx = int'(col_cnt) - int'(lead) - int'(border_q);
        pcy = int'(row_cnt) - int'(lead) - int'(border_q);
        if (pcx >= 0 && pcx < int'(width_q) && pcy >= 0 && pcy < int'(height_q)) begin
            res.center_x      = pcx[cwc_pkg::CXW-1:0];
            res.center_y      = pcy[cwc_pkg::CYW-1:0];
            res.value         = conv_value(k);
            res.last_of_frame = (pcx == int'(width_q) - 1 && pcy == int'(height_q) - 1);
            pending_q.push_back(res);
        end
        if (col_cnt + 1 >= line_len) begin
            col_cnt = 0;
            if (row_cnt + 1 >= frame_rows)
                row_cnt = 0;
            else
                row_cnt++;
        end else begin
            col_cnt++;
        end
    endfunction

    task automatic send_item(cwc_pkg::t_in it);
        if (!calm && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (full);
        predict_window(it);
    endtask

    task automatic send_pixel(logic [15:0] pix);
        cwc_pkg::t_in it;
        it.action      = cwc_pkg::ACT_PIXEL;
        it.coef_index  = 7'($urandom);
        it.coef_value  = 24'($urandom);
        it.pixel_value = pix;
        send_item(it);
    endtask

    task automatic send_coef(logic [6:0] idx, logic [23:0] val);
        cwc_pkg::t_in it;
        it.action      = cwc_pkg::ACT_COEF;
        it.coef_index  = idx;
        it.coef_value  = val;
        it.pixel_value = 16'($urandom);
        send_item(it);
    endtask

    task automatic write_reg(logic [cwc_pkg::CFG_IDXW-1:0] idx,
                             logic [cwc_pkg::CFG_DATAW-1:0] val);
        push <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            cwc_pkg::CFG_IMAGE_WIDTH:  width_q  = 32'(val[10:0]);
            cwc_pkg::CFG_IMAGE_HEIGHT: height_q = 32'(val[12:0]);
            cwc_pkg::CFG_BORDER:       border_q = 32'(val[3:0]);
            cwc_pkg::CFG_KERNEL_SIZE:  ksize_q  = 32'(val[3:0]);
            default: ;
        endcase
    endtask

    task automatic set_frame(int w, int h, int b, int k);
        write_reg(cwc_pkg::CFG_IMAGE_WIDTH, 16'(w));
        write_reg(cwc_pkg::CFG_IMAGE_HEIGHT, 16'(h));
        write_reg(cwc_pkg::CFG_BORDER, 16'(b));
        write_reg(cwc_pkg::CFG_KERNEL_SIZE, 16'(k));
    endtask

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [23:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return 24'($urandom);
            1: return 24'h7FFFFF;
            default: return 24'($urandom_range(0, 16384) - 8192);
        endcase
    endfunction

    task automatic send_frames(int n);
        for (int i = 0; i < n; i++)
            send_pixel(rand_pixel());
    endtask

    // all table entries written so no read ever hits an unwritten one
    task automatic test_coef_fill();
        for (int i = 0; i < KMAX*KMAX; i++)
            send_coef(7'(i), rand_coef());
        send_coef(7'd127, 24'h800000);
        send_coef(7'd81, 24'h7FFFFF);
    endtask

    task automatic test_extremes();
        set_frame(2, 2, 1, 3);
        for (int i = 0; i < 9; i++)
            send_coef(7'(i), (i == 4) ? 24'h010000 : 24'h000000);
        send_pixel(16'hFFFF);
        send_pixel(16'd32768);
        send_pixel(16'd0);
        send_pixel(16'd1);
        send_frames(12);
        send_coef(7'd4, 24'h800000);
        send_coef(7'd0, 24'h7FFFFF);
        send_frames(16);
    endtask

    task automatic test_kernel_sizes();
        set_frame(3, 2, 8, 0);
        send_frames(19 * 5);
        set_frame(4, 3, 2, 2);
        send_frames(8 * 7);
        set_frame(2, 2, 4, 15);
        send_frames(10 * 10);
        set_frame(3, 3, 1, 9);
        send_frames(5 * 5);
    endtask

    task automatic test_degenerate_lines();
        set_frame(0, 0, 0, 1);
        send_frames(5);
        set_frame(1, 1, 0, 1);
        send_frames(3);
        set_frame(5, 8191, 0, 3);
        send_frames(20);
    endtask

    task automatic test_wide_lines();
        set_frame(2032, 1, 0, 1);
        send_frames(60);
    endtask

    task automatic test_random();
        int w, h, b, k, n;
        while (rand_items < 560) begin
            if (rand_items > 460)
                calm = 1'b1;
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 6);
            case ($urandom_range(0, 5))
                0: k = $urandom_range(0, 15);
                1: k = 2 * $urandom_range(1, 4);
                default: k = 2 * $urandom_range(0, 4) + 1;
            endcase
            b = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8)
                                            : $urandom_range((k > 9 ? 9 : k) / 2, 8);
            set_frame(w, h, b, k);
            repeat ($urandom_range(0, 6)) begin
                send_coef(7'($urandom_range(0, 127)), rand_coef());
                rand_items++;
            end
            n = (w + 2*b) * (h + 2*b);
            if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, n);
            send_frames(n);
            rand_items += n;
        end
    endtask

    always @(posedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            pop_hold <= $urandom_range(0, 12);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cwc_pkg::t_out want;
        if (i_rst_n && pop && !empty) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result transfer x=%0d y=%0d", o_out.center_x,
                       o_out.center_y);
                err_cnt++;
            end else begin
                want = pending_q.pop_front();
                if (o_out.center_x !== want.center_x) begin
                    $error("center_x exp %0d got %0d", want.center_x, o_out.center_x);
                    err_cnt++;
                end
                if (o_out.center_y !== want.center_y) begin
                    $error("center_y exp %0d got %0d", want.center_y, o_out.center_y);
                    err_cnt++;
                end
                if (o_out.value !== want.value) begin
                    $error("value exp %0d got %0d", want.value, o_out.value);
                    err_cnt++;
                end
                if (o_out.last_of_frame !== want.last_of_frame) begin
                    $error("last_of_frame exp %0d got %0d", want.last_of_frame,
                           o_out.last_of_frame);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("tb_conv2d_window_clamp NOT OK");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        err_cnt     = 0;
        rand_items  = 0;
        calm        = 1'b0;
        width_q  = 1024;
        height_q = 1024;
        border_q = 4;
        ksize_q  = 5;
        col_cnt  = 0;
        row_cnt  = 0;
        foreach (coef_tbl[i]) coef_tbl[i] = 0;
        foreach (line_mem[r, c]) line_mem[r][c] = '0;
        foreach (win[r, c]) win[r][c] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_coef_fill();
        test_extremes();
        test_kernel_sizes();
        test_degenerate_lines();
        test_wide_lines();
        test_random();

        push <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb_conv2d_window_clamp OK");
        else
            $display("tb_conv2d_window_clamp NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cwc_pkg.sv
rtl/cwc_fifo.sv
rtl/cwc_front.sv
rtl/cwc_back.sv
rtl/conv2d_window_clamp.sv
dv/tb_conv2d_window_clamp.sv
